// ----- hw/rtl/rbs_pkg.sv -----
`default_nettype none
package rbs_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int AXES       = 3;
    localparam int LANES      = 2 * AXES;

    localparam int CFG_ADDR_BITS = 3;

    // configuration register indexes
    localparam logic [CFG_ADDR_BITS-1:0] REG_BOX_MIN_X = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_BOX_MIN_Y = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_BOX_MIN_Z = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_BOX_MAX_X = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_BOX_MAX_Y = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] REG_BOX_MAX_Z = 3'd5;

    // normal axis codes
    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    // per-ray flags that ride beside the divider lanes
    typedef struct packed {
        logic [AXES-1:0]  dir_zero;  // direction component is zero
        logic [AXES-1:0]  dir_neg;   // enters at max plane, plus normal
        logic [AXES-1:0]  miss;      // zero direction with origin outside slab
        logic [LANES-1:0] q_neg;     // quotient sign per lane (enter, leave per axis)
    } side_t;

endpackage
`default_nettype wire

// ----- hw/rtl/ray_box_slab_intersect.sv -----
`default_nettype none
// Ray versus axis-aligned box, slab test, signed fixed point (COORD_BITS total,
// FRAC_BITS fraction). Write the six box corners through the cfg port while the
// block is idle (index 0..2 min x/y/z, 3..5 max x/y/z; other indexes drop). Each
// input transaction carries one ray and yields exactly one result transaction:
// hit flag, saturated entry and exit distances, and the entering face as axis
// plus sign (axis 3 when no axis limits the ray or on a miss). A zero direction
// component imposes no limit when the origin sits inside that slab and forces
// a miss otherwise. One ray enters per clock while the output buffer has room.
// The path runs through two front stages, COORD_BITS + 1 + FRAC_BITS divider
// stages at one quotient bit per stage, three merge stages and one output
// stage. A two-entry output buffer lets the pipeline keep taking rays while a
// finished result waits on m_tready.
module ray_box_slab_intersect #(
    parameter int COORD_BITS = rbs_pkg::COORD_BITS,
    parameter int FRAC_BITS  = rbs_pkg::FRAC_BITS
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    // configuration write port
    input  wire logic                               cfg_wen,
    input  wire logic [rbs_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  wire logic [COORD_BITS-1:0]              cfg_wdata,
    // ray input
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // s_tdata from bit 0: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, zero fill
    input  wire logic [((6*COORD_BITS+7)/8)*8-1:0]  s_tdata,
    // result output
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // m_tdata from bit 0: hit, t_near, t_far, normal_axis, normal_positive, zero fill
    output logic [((2*COORD_BITS+4+7)/8)*8-1:0]     m_tdata
);
    import rbs_pkg::*;

    localparam int DIV_STEPS = COORD_BITS + 1 + FRAC_BITS;
    localparam int STAGES    = DIV_STEPS + 5;
    localparam int RES_W     = 2 * COORD_BITS + 4;
    localparam int OUT_W     = ((RES_W + 7) / 8) * 8;

    // box corners
    logic [COORD_BITS-1:0] box_lo_reg [AXES];
    logic [COORD_BITS-1:0] box_hi_reg [AXES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < AXES; a++) begin
                box_lo_reg[a] <= '0;
                box_hi_reg[a] <= '0;
            end
        end else if (cfg_wen) begin
            case (cfg_addr)
                REG_BOX_MIN_X: box_lo_reg[0] <= cfg_wdata;
                REG_BOX_MIN_Y: box_lo_reg[1] <= cfg_wdata;
                REG_BOX_MIN_Z: box_lo_reg[2] <= cfg_wdata;
                REG_BOX_MAX_X: box_hi_reg[0] <= cfg_wdata;
                REG_BOX_MAX_Y: box_hi_reg[1] <= cfg_wdata;
                REG_BOX_MAX_Z: box_hi_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // unpack ray
    logic [COORD_BITS-1:0] origin [AXES];
    logic [COORD_BITS-1:0] dir    [AXES];

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            origin[a] = s_tdata[a*COORD_BITS +: COORD_BITS];
            dir[a]    = s_tdata[(AXES+a)*COORD_BITS +: COORD_BITS];
        end
    end

    // whole pipeline advances together whenever the output buffer has room
    logic       en;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;
    logic [STAGES-1:0] valid_reg;

    assign pop      = (cnt_reg != 2'd0) && m_tready;
    assign en       = (cnt_reg != 2'd2) || m_tready;
    assign push     = en && valid_reg[STAGES-1];
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[STAGES-2:0], s_tvalid};
        end
    end

    logic [COORD_BITS:0]   num_mag [LANES];
    logic [COORD_BITS-1:0] den_mag [LANES];
    side_t                 side_front;
    logic [DIV_STEPS-1:0]  quot [LANES];
    side_t                 side_div;

    rbs_front #(.COORD_BITS(COORD_BITS)) u_front (
        .aclk    (aclk),
        .en      (en),
        .origin  (origin),
        .dir     (dir),
        .box_lo  (box_lo_reg),
        .box_hi  (box_hi_reg),
        .num_mag (num_mag),
        .den_mag (den_mag),
        .side    (side_front)
    );

    rbs_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
        .aclk     (aclk),
        .en       (en),
        .num_mag  (num_mag),
        .den_mag  (den_mag),
        .side_in  (side_front),
        .quot     (quot),
        .side_out (side_div)
    );

    logic                  r_hit;
    logic [COORD_BITS-1:0] r_near;
    logic [COORD_BITS-1:0] r_far;
    logic [1:0]            r_axis;
    logic                  r_pos;

    rbs_merge #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_merge (
        .aclk            (aclk),
        .en              (en),
        .quot            (quot),
        .side            (side_div),
        .hit             (r_hit),
        .t_near          (r_near),
        .t_far           (r_far),
        .normal_axis     (r_axis),
        .normal_positive (r_pos)
    );

    // two-entry output buffer
    logic [OUT_W-1:0] buf_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= OUT_W'({r_pos, r_axis, r_far, r_near, r_hit});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = buf_reg[rd_ptr_reg];

endmodule
`default_nettype wire

// ----- hw/rtl/rbs_front.sv -----
`default_nettype none
module rbs_front #(
    parameter int COORD_BITS = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         en,
    input  wire logic [COORD_BITS-1:0]        origin [3],
    input  wire logic [COORD_BITS-1:0]        dir    [3],
    input  wire logic [COORD_BITS-1:0]        box_lo [3],
    input  wire logic [COORD_BITS-1:0]        box_hi [3],
    output logic      [COORD_BITS:0]          num_mag [6],
    output logic      [COORD_BITS-1:0]        den_mag [6],
    output rbs_pkg::side_t                    side
);
    import rbs_pkg::*;

    logic [COORD_BITS:0]   dlo_reg [AXES];
    logic [COORD_BITS:0]   dhi_reg [AXES];
    logic [COORD_BITS-1:0] dir_reg [AXES];

    logic [COORD_BITS:0]   num_next [LANES];
    logic [COORD_BITS-1:0] den_next [LANES];
    side_t                 side_next;

    // stage 1: plane minus origin on both planes
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int a = 0; a < AXES; a++) begin
                dlo_reg[a] <= {box_lo[a][COORD_BITS-1], box_lo[a]}
                            - {origin[a][COORD_BITS-1], origin[a]};
                dhi_reg[a] <= {box_hi[a][COORD_BITS-1], box_hi[a]}
                            - {origin[a][COORD_BITS-1], origin[a]};
                dir_reg[a] <= dir[a];
            end
        end
    end

    // stage 2: order planes by direction sign, take magnitudes
    always_comb begin
        logic                  dneg;
        logic [COORD_BITS:0]   en_num;
        logic [COORD_BITS:0]   lv_num;
        logic [COORD_BITS-1:0] dmag;
        side_next = '0;
        for (int a = 0; a < AXES; a++) begin
            dneg   = dir_reg[a][COORD_BITS-1];
            en_num = dneg ? dhi_reg[a] : dlo_reg[a];
            lv_num = dneg ? dlo_reg[a] : dhi_reg[a];
            dmag   = dneg ? (~dir_reg[a] + 1'b1) : dir_reg[a];
            num_next[2*a]     = en_num[COORD_BITS] ? (~en_num + 1'b1) : en_num;
            num_next[2*a + 1] = lv_num[COORD_BITS] ? (~lv_num + 1'b1) : lv_num;
            den_next[2*a]     = dmag;
            den_next[2*a + 1] = dmag;
            side_next.dir_zero[a] = (dir_reg[a] == '0);
            side_next.dir_neg[a]  = dneg;
            side_next.miss[a]     = (dir_reg[a] == '0)
                && ((!dlo_reg[a][COORD_BITS] && dlo_reg[a] != '0) || dhi_reg[a][COORD_BITS]);
            side_next.q_neg[2*a]     = en_num[COORD_BITS] ^ dneg;
            side_next.q_neg[2*a + 1] = lv_num[COORD_BITS] ^ dneg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_mag <= num_next;
            den_mag <= den_next;
            side    <= side_next;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/rbs_div.sv -----
`default_nettype none
module rbs_div #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 en,
    input  wire logic [COORD_BITS:0]                  num_mag [6],
    input  wire logic [COORD_BITS-1:0]                den_mag [6],
    input  wire rbs_pkg::side_t                       side_in,
    output logic      [COORD_BITS+FRAC_BITS:0]        quot    [6],
    output rbs_pkg::side_t                            side_out
);
    import rbs_pkg::*;

    localparam int STEPS = COORD_BITS + 1 + FRAC_BITS;

    // restoring division, one quotient bit per stage; quotient bits fill
    // the low end of the dividend word as it shifts out
    logic [COORD_BITS-1:0] rem_reg [STEPS][LANES];
    logic [STEPS-1:0]      dq_reg  [STEPS][LANES];
    logic [COORD_BITS-1:0] den_reg [STEPS][LANES];
    side_t                 side_reg [STEPS];

    for (genvar s = 0; s < STEPS; s++) begin : g_step
        logic [COORD_BITS-1:0] rem_in [LANES];
        logic [STEPS-1:0]      dq_in  [LANES];
        logic [COORD_BITS-1:0] den_in [LANES];
        side_t                 side_prev;

        if (s == 0) begin : g_head
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    rem_in[l] = '0;
                    dq_in[l]  = {num_mag[l], {FRAC_BITS{1'b0}}};
                    den_in[l] = den_mag[l];
                end
                side_prev = side_in;
            end
        end else begin : g_tail
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    rem_in[l] = rem_reg[s-1][l];
                    dq_in[l]  = dq_reg[s-1][l];
                    den_in[l] = den_reg[s-1][l];
                end
                side_prev = side_reg[s-1];
            end
        end

        always_ff @(posedge aclk) begin
            logic [COORD_BITS:0] trial;
            logic                ge;
            if (en) begin
                for (int l = 0; l < LANES; l++) begin
                    trial = {rem_in[l], dq_in[l][STEPS-1]};
                    ge    = trial >= {1'b0, den_in[l]};
                    rem_reg[s][l] <= ge ? COORD_BITS'(trial - {1'b0, den_in[l]})
                                        : trial[COORD_BITS-1:0];
                    dq_reg[s][l]  <= {dq_in[l][STEPS-2:0], ge};
                    den_reg[s][l] <= den_in[l];
                end
                side_reg[s] <= side_prev;
            end
        end
    end

    assign quot     = dq_reg[STEPS-1];
    assign side_out = side_reg[STEPS-1];

endmodule
`default_nettype wire

// ----- hw/rtl/rbs_merge.sv -----
`default_nettype none
module rbs_merge #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire logic [COORD_BITS+FRAC_BITS:0] quot [6],
    input  wire rbs_pkg::side_t                side,
    output logic                               hit,
    output logic [COORD_BITS-1:0]              t_near,
    output logic [COORD_BITS-1:0]              t_far,
    output logic [1:0]                         normal_axis,
    output logic                               normal_positive
);
    import rbs_pkg::*;

    localparam int QW = COORD_BITS + 1 + FRAC_BITS;
    localparam logic [COORD_BITS-1:0] CHALF = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic [COORD_BITS-1:0] SMAX  = {1'b0, {(COORD_BITS-1){1'b1}}};

    typedef struct packed {
        logic                  lim;
        logic [COORD_BITS-1:0] near;
        logic [COORD_BITS-1:0] far;
        logic [1:0]            axis;
        logic                  pos;
    } acc_t;

    localparam acc_t ACC_INIT = '{lim: 1'b0, near: CHALF, far: SMAX,
                                  axis: AXIS_NONE, pos: 1'b0};

    function automatic acc_t fold(input acc_t acc, input logic zero,
                                  input logic [COORD_BITS-1:0] enter,
                                  input logic [COORD_BITS-1:0] leave,
                                  input logic [1:0] idx, input logic p);
        acc_t r;
        r = acc;
        if (!zero) begin
            if (!acc.lim || $signed(enter) > $signed(acc.near)) begin
                r.near = enter;
                r.axis = idx;
                r.pos  = p;
            end
            if (!acc.lim || $signed(leave) < $signed(acc.far)) begin
                r.far = leave;
            end
            r.lim = 1'b1;
        end
        return r;
    endfunction

    // stage 1: saturate and apply sign
    logic [COORD_BITS-1:0] t_reg [LANES];
    side_t                 side_reg;

    always_ff @(posedge aclk) begin
        logic over;
        logic at_half;
        logic [COORD_BITS-1:0] mag;
        if (en) begin
            for (int l = 0; l < LANES; l++) begin
                at_half = quot[l][QW-1:COORD_BITS-1] != '0;
                over    = (quot[l][QW-1:COORD_BITS] != '0)
                       || (quot[l][COORD_BITS-1] && quot[l][COORD_BITS-2:0] != '0);
                if (side.q_neg[l]) begin
                    mag = over ? CHALF : quot[l][COORD_BITS-1:0];
                    t_reg[l] <= ~mag + 1'b1;
                end else begin
                    t_reg[l] <= at_half ? SMAX : quot[l][COORD_BITS-1:0];
                end
            end
            side_reg <= side;
        end
    end

    // stage 2: fold x and y
    acc_t                  acc_reg;
    logic                  miss_reg;
    logic                  zz_reg;
    logic                  zneg_reg;
    logic [COORD_BITS-1:0] zen_reg;
    logic [COORD_BITS-1:0] zlv_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            acc_reg  <= fold(fold(ACC_INIT, side_reg.dir_zero[0], t_reg[0], t_reg[1],
                                  AXIS_X, side_reg.dir_neg[0]),
                             side_reg.dir_zero[1], t_reg[2], t_reg[3],
                             AXIS_Y, side_reg.dir_neg[1]);
            miss_reg <= |side_reg.miss;
            zz_reg   <= side_reg.dir_zero[2];
            zneg_reg <= side_reg.dir_neg[2];
            zen_reg  <= t_reg[4];
            zlv_reg  <= t_reg[5];
        end
    end

    // stage 3: fold z, decide hit
    always_ff @(posedge aclk) begin
        acc_t fin;
        if (en) begin
            fin = fold(acc_reg, zz_reg, zen_reg, zlv_reg, AXIS_Z, zneg_reg);
            if (miss_reg || $signed(fin.near) > $signed(fin.far)) begin
                hit             <= 1'b0;
                t_near          <= '0;
                t_far           <= '0;
                normal_axis     <= AXIS_NONE;
                normal_positive <= 1'b0;
            end else begin
                hit             <= 1'b1;
                t_near          <= fin.near;
                t_far           <= fin.far;
                normal_axis     <= fin.axis;
                normal_positive <= fin.pos;
            end
        end
    end

endmodule
`default_nettype wire
